/* rtl/core/lsf_pkg.sv */
// ============================================================================
// lsf_pkg
// Shared widths, codes and defaults for the learning switch forwarder.
// ============================================================================
package lsf_pkg;

    // Item field widths
    localparam int ADDR_W    = 8;
    localparam int PORT_W    = 3;
    localparam int NUM_PORTS = 8;
    localparam int MASK_W    = NUM_PORTS;

    // Default address table size
    localparam int NUM_ADDRESSES_DEFAULT = 256;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PORT_MASK = 1'b0
    } reg_idx_t;

    typedef enum logic [0:0] {
        CMD_FORWARD = 1'b0,
        CMD_INSTALL = 1'b1
    } cmd_t;

endpackage

/* rtl/core/lsf_channels.sv */
// ============================================================================
// lsf channel interfaces
// Valid/ready channels for frame items and forwarding decision items.
// ============================================================================
interface lsf_frame_if
    import lsf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [0:0]        cmd;
    logic [ADDR_W-1:0] source_addr;
    logic [ADDR_W-1:0] dest_addr;
    logic [PORT_W-1:0] in_port;

    modport source (output valid, cmd, source_addr, dest_addr, in_port, input ready);
    modport sink   (input valid, cmd, source_addr, dest_addr, in_port, output ready);
endinterface

interface lsf_decision_if
    import lsf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] forward_mask;
    logic              flooded;
    logic              hit;

    modport source (output valid, forward_mask, flooded, hit, input ready);
    modport sink   (input valid, forward_mask, flooded, hit, output ready);
endinterface

/* rtl/core/learning_switch_forwarder_core.sv */
// ============================================================================
// learning_switch_forwarder_core
// Learning bridge forwarding decision: learns source to port, looks up the
// destination, and floods on a miss.
// ============================================================================
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+---------------------------------------
//  frame     | in  | valid/ready   | cmd, source_addr, dest_addr, in_port
//  decision  | out | valid/ready   | forward_mask, flooded, hit
//  apb       | in  | psel/penable  | port_mask at byte address 0
//
//  One item per cycle while the decision side is not stalled. The acceptance
//  edge reads the port memory into the lookup stage, which then loads the
//  decision register once the output is free. Learn write and lookup read
//  share the acceptance edge; a lookup of the address being learned is bypassed.
//  Reset clears all valid bits at once; no sweep, items accepted right away.
//  A stalled decision holds the result stage, which then drops frame.ready.
//
module learning_switch_forwarder_core
    import lsf_pkg::*;
#(
    parameter int NUM_ADDRESSES = NUM_ADDRESSES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lsf_frame_if.sink             frame,
    lsf_decision_if.source        decision,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Addresses are 8 bits wide, so at most 256 entries are reachable.
    localparam int ADDR_SPAN   = 1 << ADDR_W;
    localparam int TABLE_DEPTH = (NUM_ADDRESSES < ADDR_SPAN) ? NUM_ADDRESSES : ADDR_SPAN;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    // rounded-up reciprocal; exact quotient for every 8-bit address
    localparam int RECIP       = (65536 + TABLE_DEPTH - 1) / TABLE_DEPTH;

    // addr mod TABLE_DEPTH by reciprocal multiplication
    function automatic logic [IDX_W-1:0] table_index(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W+15:0] prod;
        logic [ADDR_W-1:0]  quo;
        logic [15:0]        back;
        logic [15:0]        rem;
        prod = {16'b0, addr} * (ADDR_W+16)'(RECIP);
        quo  = prod[ADDR_W+15:16];
        back = 16'(quo) * 16'(TABLE_DEPTH);
        rem  = 16'(addr) - back;
        return rem[IDX_W-1:0];
    endfunction

    logic [MASK_W-1:0]      port_mask_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [PORT_W-1:0]      port_mem [TABLE_DEPTH];
    logic [PORT_W-1:0]      rd_port_reg;

    logic                   s1_valid_reg;
    logic [0:0]             s1_cmd_reg;
    logic [PORT_W-1:0]      s1_in_port_reg;
    logic                   s1_bypass_reg;
    logic                   s1_entry_valid_reg;

    logic                   out_valid_reg;
    logic [MASK_W-1:0]      out_mask_reg;
    logic                   out_flooded_reg;
    logic                   out_hit_reg;

    logic                   frame_acc;
    logic                   s1_move;
    logic [IDX_W-1:0]       src_idx;
    logic [IDX_W-1:0]       dst_idx;
    logic                   cfg_write;

    logic [MASK_W-1:0]      mask_next;
    logic                   flooded_next;
    logic                   hit_next;
    logic [PORT_W-1:0]      hit_port;

    assign src_idx   = table_index(frame.source_addr);
    assign dst_idx   = table_index(frame.dest_addr);

    assign s1_move   = s1_valid_reg && (!out_valid_reg || decision.ready);
    assign frame.ready = !s1_valid_reg || s1_move;
    assign frame_acc = frame.valid && frame.ready;

    // ---- configuration port ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1 -: REG_IDX_W] == REG_PORT_MASK);

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1 -: REG_IDX_W] == REG_PORT_MASK)
        begin
            prdata = {{(APB_DATA_W-MASK_W){1'b0}}, port_mask_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            port_mask_reg <= pwdata[MASK_W-1:0];
        end
    end

    // ---- port memory: learn write and lookup read in the same cycle ----
    always_ff @(posedge clk)
    begin
        if (frame_acc)
        begin
            port_mem[src_idx] <= frame.in_port;
            rd_port_reg       <= port_mem[dst_idx];
        end
    end

    // ---- valid bits, cleared at reset ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (frame_acc)
        begin
            valid_reg[src_idx] <= 1'b1;
        end
    end

    // ---- lookup stage ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (frame_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_acc)
        begin
            s1_cmd_reg         <= frame.cmd;
            s1_in_port_reg     <= frame.in_port;
            // same-cycle learn of the looked-up address: memory returns old data
            s1_bypass_reg      <= (src_idx == dst_idx);
            s1_entry_valid_reg <= valid_reg[dst_idx];
        end
    end

    assign hit_port = s1_bypass_reg ? s1_in_port_reg : rd_port_reg;

    always_comb
    begin
        mask_next    = '0;
        flooded_next = 1'b0;
        hit_next     = 1'b0;
        if (s1_cmd_reg == CMD_FORWARD)
        begin
            if (s1_bypass_reg || s1_entry_valid_reg)
            begin
                mask_next = MASK_W'(1) << hit_port;
                hit_next  = 1'b1;
            end
            else
            begin
                mask_next    = port_mask_reg & ~(MASK_W'(1) << s1_in_port_reg);
                flooded_next = 1'b1;
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (decision.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_mask_reg    <= mask_next;
            out_flooded_reg <= flooded_next;
            out_hit_reg     <= hit_next;
        end
    end

    assign decision.valid        = out_valid_reg;
    assign decision.forward_mask = out_mask_reg;
    assign decision.flooded      = out_flooded_reg;
    assign decision.hit          = out_hit_reg;

endmodule

/* rtl/core/lsf_checker.sv */
// ============================================================================
// lsf_checker
// Port-level checks on the forwarder's decision stream.
// ============================================================================
module lsf_checker
    import lsf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              frame_valid,
    input logic              frame_ready,
    input logic              decision_valid,
    input logic              decision_ready,
    input logic [MASK_W-1:0] forward_mask,
    input logic              flooded,
    input logic              hit
);

    // a stalled decision stays up
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        decision_valid && !decision_ready |=> decision_valid)
        else $error("decision dropped while stalled");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        decision_valid |-> !(hit && flooded))
        else $error("hit and flooded both set");

    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        decision_valid && hit |-> $onehot(forward_mask))
        else $error("hit without a single port");

    // install items forward nothing
    a_install_zero: assert property (@(posedge clk) disable iff (!rst_n)
        decision_valid && !hit && !flooded |-> forward_mask == '0)
        else $error("install item with nonzero mask");

    // an accepted frame reaches the decision register through the lookup stage when the output side is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && !decision_valid |=> ##1 decision_valid)
        else $error("decision missing two cycles after frame");

endmodule

bind learning_switch_forwarder_core lsf_checker u_lsf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_valid    (frame.valid),
    .frame_ready    (frame.ready),
    .decision_valid (decision.valid),
    .decision_ready (decision.ready),
    .forward_mask   (decision.forward_mask),
    .flooded        (decision.flooded),
    .hit            (decision.hit)
);
